>>> hw/rtl/tpsc_pkg.sv
// Shared types and constants for the two-point sensor calibration unit.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tpsc_pkg;

   localparam int DATA_W    = 16;
   localparam int DIV_STEPS = 16;
   localparam int CNT_W     = 4;

   localparam logic [DATA_W-1:0] FULL_SCALE = 16'hFFFF;

   // Op codes; the unused code calibrates only
   localparam logic [1:0] OP_CALIBRATE   = 2'd0;
   localparam logic [1:0] OP_LATCH_LOWER = 2'd1;
   localparam logic [1:0] OP_LATCH_UPPER = 2'd2;

   // Control register indexes
   localparam logic CSR_SENSOR_COUNT = 1'b0;
   localparam logic CSR_MODE_COUNT   = 1'b1;

   localparam logic [7:0] SENSOR_COUNT_RESET = 8'd128;
   localparam logic [2:0] MODE_COUNT_RESET   = 3'd5;

   typedef struct packed {
      logic clear_en;
      logic capture;
      logic check;
      logic div_step;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic quick_result;
      logic div_last;
   } status_type;

endpackage

`default_nettype wire

>>> hw/rtl/tpsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tpsc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 640,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> hw/rtl/tpsc_ctrl.sv
// Controller FSM: clearing pass, table read, reference check, divide, respond.
// Depends on tpsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpsc_ctrl
   import tpsc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire status_type status,
   output cmd_type         cmd,
   output logic            busy
);

   typedef enum logic [5:0] {
      S_CLEAR   = 6'b000001,
      S_IDLE    = 6'b000010,
      S_READ    = 6'b000100,
      S_CHECK   = 6'b001000,
      S_DIVIDE  = 6'b010000,
      S_RESPOND = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) state_in = S_READ;
         end
         S_READ:   state_in = S_CHECK;
         S_CHECK: begin
            state_in = status.quick_result ? S_RESPOND : S_DIVIDE;
         end
         S_DIVIDE: begin
            if (status.div_last) state_in = S_RESPOND;
         end
         S_RESPOND: state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy         = (state_ff != S_IDLE);
   assign cmd.clear_en = (state_ff == S_CLEAR);
   assign cmd.capture  = (state_ff == S_IDLE) && start;
   assign cmd.check    = (state_ff == S_CHECK);
   assign cmd.div_step = (state_ff == S_DIVIDE);
   assign cmd.respond  = (state_ff == S_RESPOND);

endmodule

`default_nettype wire

>>> hw/rtl/tpsc_datapath.sv
// Datapath: request capture, reference tables, latch and compare, radix-2 divider.
// Depends on tpsc_pkg and tpsc_ram.
`timescale 1ns / 1ps
`default_nettype none

module tpsc_datapath
   import tpsc_pkg::*;
#(
   parameter int SENSORS = 128,
   parameter int MODES   = 5
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output status_type       status,
   input  wire logic [7:0]  sensor_count,
   input  wire logic [2:0]  mode_count,
   input  wire logic [1:0]  req_op,
   input  wire logic [2:0]  req_mode,
   input  wire logic [6:0]  req_sensor_index,
   input  wire logic [15:0] req_raw_value,
   output logic [15:0]      calibrated_value,
   output logic [2:0]       out_mode,
   output logic [6:0]       out_sensor_index,
   output logic             error
);

   localparam int DEPTH = MODES * SENSORS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [1:0]        op_ff;
   logic [2:0]        mode_ff;
   logic [6:0]        sidx_ff;
   logic [DATA_W-1:0] raw_ff;
   logic              err_ff;
   logic [AW-1:0]     addr_ff;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [DATA_W-1:0] span_ff, span_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic              err_in;
   logic [AW-1:0]     addr_in;
   logic [DATA_W-1:0] lo_rdata, hi_rdata, lo, hi, diff;
   logic [2*DATA_W-1:0] num;
   logic              is_zero, is_sat;
   logic [DATA_W:0]   trial;
   logic              ge;

   logic              lo_we, hi_we;
   logic [AW-1:0]     waddr;
   logic [DATA_W-1:0] wdata;

   // Range check and table address of the incoming request
   always_comb begin
      err_in = (req_mode >= mode_count) || (int'(req_mode) >= MODES) ||
               ({1'b0, req_sensor_index} >= sensor_count) ||
               (int'(req_sensor_index) >= SENSORS);
      addr_in = err_in ? '0
                       : AW'(int'(req_mode) * SENSORS + int'(req_sensor_index));
   end

   // Latched sample overrides the stored reference
   always_comb begin
      lo = lo_rdata;
      hi = hi_rdata;
      case (op_ff)
         OP_LATCH_LOWER: lo = raw_ff;
         OP_LATCH_UPPER: hi = raw_ff;
         default: ;
      endcase
      is_zero = err_ff || (raw_ff <= lo) || (hi <= lo);
      is_sat  = (raw_ff >= hi);
      diff    = raw_ff - lo;
      // diff * 65535
      num     = {diff, {DATA_W{1'b0}}} - {{DATA_W{1'b0}}, diff};
   end

   // Restoring divide step; remainder always stays below the span
   always_comb begin
      trial = {rem_ff, q_ff[DATA_W-1]};
      ge    = (trial >= {1'b0, span_ff});
   end

   always_comb begin
      clr_addr_in = clr_addr_ff;
      span_in     = span_ff;
      rem_in      = rem_ff;
      q_in        = q_ff;
      cnt_in      = cnt_ff;
      if (cmd.clear_en) begin
         clr_addr_in = clr_addr_ff + AW'(1);
      end
      if (cmd.check) begin
         span_in = hi - lo;
         rem_in  = num[2*DATA_W-1:DATA_W];
         cnt_in  = '0;
         if (is_zero) begin
            q_in = '0;
         end else if (is_sat) begin
            q_in = FULL_SCALE;
         end else begin
            q_in = num[DATA_W-1:0];
         end
      end
      if (cmd.div_step) begin
         rem_in = ge ? DATA_W'(trial - {1'b0, span_ff}) : trial[DATA_W-1:0];
         q_in   = {q_ff[DATA_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_op;
         mode_ff <= req_mode;
         sidx_ff <= req_sensor_index;
         raw_ff  <= req_raw_value;
         err_ff  <= err_in;
         addr_ff <= addr_in;
      end
      span_ff <= span_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
   end

   // Table writes: clearing pass, or reference latch
   always_comb begin
      waddr = cmd.clear_en ? clr_addr_ff : addr_ff;
      wdata = cmd.clear_en ? '0 : raw_ff;
      lo_we = cmd.clear_en || (cmd.check && !err_ff && (op_ff == OP_LATCH_LOWER));
      hi_we = cmd.clear_en || (cmd.check && !err_ff && (op_ff == OP_LATCH_UPPER));
   end

   tpsc_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_lower_ram (
      .clock (clock),
      .we    (lo_we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (addr_ff),
      .rdata (lo_rdata)
   );

   tpsc_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_upper_ram (
      .clock (clock),
      .we    (hi_we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (addr_ff),
      .rdata (hi_rdata)
   );

   assign status.clear_last   = (clr_addr_ff == AW'(DEPTH - 1));
   assign status.quick_result = is_zero || is_sat;
   assign status.div_last     = (cnt_ff == CNT_W'(DIV_STEPS - 1));

   assign calibrated_value = q_ff;
   assign out_mode         = mode_ff;
   assign out_sensor_index = sidx_ff;
   assign error            = err_ff;

endmodule

`default_nettype wire

>>> hw/rtl/two_point_sensor_calibration_unit.sv
// Two-point sensor calibration unit: top level, control registers, assertions.
// Depends on tpsc_pkg, tpsc_ctrl, tpsc_datapath (and tpsc_ram below it).
//
// A transaction is taken when start is high and busy is low. Each one produces
// exactly one response, shown for a single cycle with rsp_valid; the receiver
// cannot stall it. Per (mode, sensor) pair the unit keeps a lower and an upper
// reference in two RAMs; op 1 / op 2 latch the sample as lower / upper first.
// Result: 0 if raw <= lower or upper <= lower, else
// floor((raw-lower)*65535/(upper-lower)) capped at 65535. An out-of-range mode
// or index sets rsp_error, gives 0 and leaves the tables untouched.
// Flow: a transaction settled by the reference compare (zero, error, or
// raw >= upper) goes from the check straight to the response; otherwise the
// 16-step radix-2 restoring divider runs in between. busy drops on the cycle
// after rsp_valid. After reset the tables are zeroed by a clearing pass over all
// MODES*SENSORS entries (640 by default), one entry per cycle, during which busy
// stays high; CSR writes are taken at any time (csr_ready is always high).
`timescale 1ns / 1ps
`default_nettype none

module two_point_sensor_calibration_unit
   import tpsc_pkg::*;
#(
   parameter int SENSORS = 128,
   parameter int MODES   = 5
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_op,
   input  wire logic [2:0]  req_mode,
   input  wire logic [6:0]  req_sensor_index,
   input  wire logic [15:0] req_raw_value,
   // response
   output logic             rsp_valid,
   output logic [15:0]      rsp_calibrated_value,
   output logic [2:0]       rsp_out_mode,
   output logic [6:0]       rsp_out_sensor_index,
   output logic             rsp_error,
   // control registers
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   logic [7:0] sensor_count_ff, sensor_count_in;
   logic [2:0] mode_count_ff, mode_count_in;

   // Registers are always writable; only written while idle by contract
   assign csr_ready = 1'b1;

   always_comb begin
      sensor_count_in = sensor_count_ff;
      mode_count_in   = mode_count_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SENSOR_COUNT: sensor_count_in = csr_wdata;
            CSR_MODE_COUNT:   mode_count_in   = csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_count_ff <= SENSOR_COUNT_RESET;
         mode_count_ff   <= MODE_COUNT_RESET;
      end else begin
         sensor_count_ff <= sensor_count_in;
         mode_count_ff   <= mode_count_in;
      end
   end

   tpsc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   tpsc_datapath #(.SENSORS(SENSORS), .MODES(MODES)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .sensor_count     (sensor_count_ff),
      .mode_count       (mode_count_ff),
      .req_op           (req_op),
      .req_mode         (req_mode),
      .req_sensor_index (req_sensor_index),
      .req_raw_value    (req_raw_value),
      .calibrated_value (rsp_calibrated_value),
      .out_mode         (rsp_out_mode),
      .out_sensor_index (rsp_out_sensor_index),
      .error            (rsp_error)
   );

   assign rsp_valid = cmd.respond;

   // Response only while a transaction is in flight
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("response outside a transaction");

   // An accepted transaction keeps the unit busy on the next cycle
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // Errored transactions always report zero
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp_error) |-> (rsp_calibrated_value == '0))
      else $error("error response with nonzero value");

   // busy drops right after a response
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !busy)
      else $error("busy held after response");

endmodule

`default_nettype wire
